// ----- rtl/core/tarit_pkg.sv -----
// ----------------------------------------------------------------------------
// tarit_pkg
// shared types and constants for the typed allocation range table
// ----------------------------------------------------------------------------
package tarit_pkg;

  localparam int TYPE_W  = 16;
  localparam int COUNT_W = 32;
  localparam int SIZE_W  = 16;
  localparam int EXT_W   = COUNT_W + SIZE_W;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_BADALIGN = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

// ----- rtl/core/typed_allocation_range_table_top.sv -----
// ----------------------------------------------------------------------------
// typed_allocation_range_table_top
// table of typed allocations with insert, remove and range lookup
// ----------------------------------------------------------------------------
// every transaction scans the entry memory through its single read port,
// one entry a cycle
// a lookup that reaches the divider then runs a bit-serial divide by the
// element size
// one transaction at a time; the next is taken once the result is registered
// reset clears all valid bits and control state at once, no clearing pass
module typed_allocation_range_table_top
  import tarit_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int ADDRESS_BITS  = 48
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_op,
  input  logic [ADDRESS_BITS-1:0] in_address,
  input  logic [TYPE_W-1:0]       in_type_code,
  input  logic [COUNT_W-1:0]      in_element_total,
  input  logic [SIZE_W-1:0]       in_element_bytes,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic [TYPE_W-1:0]       out_found_type,
  output logic [COUNT_W-1:0]      out_remaining_elements
);

  localparam int AW   = ADDRESS_BITS;
  localparam int IW   = $clog2(TABLE_ENTRIES);
  localparam int ENTW = AW + TYPE_W + COUNT_W + SIZE_W;
  localparam int CW   = (AW > EXT_W) ? AW : EXT_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_MUL  = 6'b000100,
    S_CHK  = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  logic [ENTW-1:0] mem [TABLE_ENTRIES];
  logic [ENTW-1:0] mem_q_r;
  logic [IW-1:0]   rd_addr;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  logic [ENTW-1:0] wr_data;

  state_t state_r, state_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [IW:0]   cnt_r, cnt_nxt;
  logic          rd_v_r, rd_v_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;

  logic [1:0]         op_r;
  logic [AW-1:0]      addr_r;
  logic [TYPE_W-1:0]  ty_r;
  logic [COUNT_W-1:0] tot_r;
  logic [SIZE_W-1:0]  sz_r;

  logic               ex_hit_r, ex_hit_nxt;
  logic [IW-1:0]      ex_idx_r, ex_idx_nxt;
  logic [TYPE_W-1:0]  ex_type_r, ex_type_nxt;
  logic [COUNT_W-1:0] ex_count_r, ex_count_nxt;
  logic               fr_hit_r, fr_hit_nxt;
  logic [IW-1:0]      fr_idx_r, fr_idx_nxt;
  logic               bs_hit_r, bs_hit_nxt;
  logic [AW-1:0]      bs_base_r, bs_base_nxt;
  logic [TYPE_W-1:0]  bs_type_r, bs_type_nxt;
  logic [COUNT_W-1:0] bs_count_r, bs_count_nxt;
  logic [SIZE_W-1:0]  bs_size_r, bs_size_nxt;

  logic [EXT_W-1:0] ext_r, ext_nxt;
  logic [AW-1:0]    off_r, off_nxt;

  status_t            res_st_r, res_st_nxt;
  logic [TYPE_W-1:0]  res_ty_r, res_ty_nxt;
  logic [COUNT_W-1:0] res_rem_r, res_rem_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_st_r;
  logic [TYPE_W-1:0]  out_ty_r;
  logic [COUNT_W-1:0] out_rem_r;
  logic               out_load;

  logic [AW-1:0]      e_base;
  logic [TYPE_W-1:0]  e_type;
  logic [COUNT_W-1:0] e_count;
  logic [SIZE_W-1:0]  e_size;
  logic               e_valid;

  logic               div_start;
  div_ctl_t           div_ctl;
  logic [EXT_W-1:0]   div_q;
  logic [SIZE_W-1:0]  div_r;

  assign {e_base, e_type, e_count, e_size} = mem_q_r;
  assign e_valid = valid_r[rd_idx_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q_r <= mem[rd_addr];
  end

  tarit_div #(.W(EXT_W), .DW(SIZE_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (EXT_W'(off_r)),
    .divisor   (bs_size_r),
    .ctl       (div_ctl),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    cnt_nxt      = cnt_r;
    rd_v_nxt     = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    rd_addr      = cnt_r[IW-1:0];
    ex_hit_nxt   = ex_hit_r;
    ex_idx_nxt   = ex_idx_r;
    ex_type_nxt  = ex_type_r;
    ex_count_nxt = ex_count_r;
    fr_hit_nxt   = fr_hit_r;
    fr_idx_nxt   = fr_idx_r;
    bs_hit_nxt   = bs_hit_r;
    bs_base_nxt  = bs_base_r;
    bs_type_nxt  = bs_type_r;
    bs_count_nxt = bs_count_r;
    bs_size_nxt  = bs_size_r;
    ext_nxt      = ext_r;
    off_nxt      = off_r;
    res_st_nxt   = res_st_r;
    res_ty_nxt   = res_ty_r;
    res_rem_nxt  = res_rem_r;
    wr_en        = 1'b0;
    wr_addr      = ex_hit_r ? ex_idx_r : fr_idx_r;
    wr_data      = {addr_r, ty_r, tot_r, sz_r};
    div_start    = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt  = S_SCAN;
          cnt_nxt    = '0;
          ex_hit_nxt = 1'b0;
          fr_hit_nxt = 1'b0;
          bs_hit_nxt = 1'b0;
          bs_base_nxt = '0;
        end
      end
      S_SCAN: begin
        if (cnt_r != (IW+1)'(TABLE_ENTRIES)) begin
          rd_v_nxt   = 1'b1;
          rd_idx_nxt = cnt_r[IW-1:0];
          cnt_nxt    = cnt_r + (IW+1)'(1);
        end
        if (rd_v_r) begin
          if (e_valid && e_base == addr_r && !ex_hit_r) begin
            ex_hit_nxt   = 1'b1;
            ex_idx_nxt   = rd_idx_r;
            ex_type_nxt  = e_type;
            ex_count_nxt = e_count;
          end
          if (!e_valid && !fr_hit_r) begin
            fr_hit_nxt = 1'b1;
            fr_idx_nxt = rd_idx_r;
          end
          if (e_valid && e_base < addr_r && e_base > bs_base_r) begin
            bs_hit_nxt   = 1'b1;
            bs_base_nxt  = e_base;
            bs_type_nxt  = e_type;
            bs_count_nxt = e_count;
            bs_size_nxt  = e_size;
          end
        end else if (cnt_r == (IW+1)'(TABLE_ENTRIES)) begin
          state_nxt   = S_DONE;
          res_st_nxt  = ST_UNKNOWN;
          res_ty_nxt  = '0;
          res_rem_nxt = '0;
          unique case (op_t'(op_r))
            OP_ALLOC: begin
              if (ex_hit_r || fr_hit_r) begin
                wr_en              = 1'b1;
                valid_nxt[wr_addr] = 1'b1;
                res_st_nxt         = ST_OK;
              end else begin
                res_st_nxt = ST_FULL;
              end
            end
            OP_FREE: begin
              if (ex_hit_r) begin
                valid_nxt[ex_idx_r] = 1'b0;
                res_st_nxt          = ST_OK;
              end
            end
            OP_LOOKUP: begin
              if (ex_hit_r) begin
                res_st_nxt  = ST_OK;
                res_ty_nxt  = ex_type_r;
                res_rem_nxt = ex_count_r;
              end else if (bs_hit_r) begin
                state_nxt = S_MUL;
              end
            end
            default: begin
              res_st_nxt = ST_UNKNOWN;
            end
          endcase
        end
      end
      S_MUL: begin
        ext_nxt   = EXT_W'(bs_count_r) * EXT_W'(bs_size_r);
        off_nxt   = addr_r - bs_base_r;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (CW'(off_r) >= CW'(ext_r)) begin
          state_nxt = S_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_ctl.done) begin
          state_nxt = S_DONE;
          if (div_r != '0) begin
            res_st_nxt = ST_BADALIGN;
          end else begin
            res_st_nxt  = ST_OK;
            res_ty_nxt  = bs_type_r;
            res_rem_nxt = bs_count_r - div_q[COUNT_W-1:0];
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      cnt_r       <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      op_r   <= in_op;
      addr_r <= in_address;
      ty_r   <= in_type_code;
      tot_r  <= in_element_total;
      sz_r   <= in_element_bytes;
    end
    rd_idx_r   <= rd_idx_nxt;
    ex_hit_r   <= ex_hit_nxt;
    ex_idx_r   <= ex_idx_nxt;
    ex_type_r  <= ex_type_nxt;
    ex_count_r <= ex_count_nxt;
    fr_hit_r   <= fr_hit_nxt;
    fr_idx_r   <= fr_idx_nxt;
    bs_hit_r   <= bs_hit_nxt;
    bs_base_r  <= bs_base_nxt;
    bs_type_r  <= bs_type_nxt;
    bs_count_r <= bs_count_nxt;
    bs_size_r  <= bs_size_nxt;
    ext_r      <= ext_nxt;
    off_r      <= off_nxt;
    res_st_r   <= res_st_nxt;
    res_ty_r   <= res_ty_nxt;
    res_rem_r  <= res_rem_nxt;
    if (out_load) begin
      out_st_r  <= res_st_r;
      out_ty_r  <= res_ty_r;
      out_rem_r <= res_rem_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_st_r;
  assign out_found_type         = out_ty_r;
  assign out_remaining_elements = out_rem_r;

`ifndef ASSERT_OFF
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_SCAN && cnt_r == '0))
    else $error("accepted transaction did not start a scan");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (IW+1)'(TABLE_ENTRIES))
    else $error("scan counter beyond table");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_found_type == '0 && out_remaining_elements == '0))
    else $error("failed transaction carries nonzero fields");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.done |-> state_r == S_DIV)
    else $error("divider finished outside divide state");
`endif

endmodule

// ----- rtl/core/tarit_div.sv -----
// ----------------------------------------------------------------------------
// tarit_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tarit_div
  import tarit_pkg::*;
#(
  parameter int W  = 48,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [W-1:0]  dividend,
  input  logic [DW-1:0] divisor,
  output div_ctl_t      ctl,
  output logic [W-1:0]  quotient,
  output logic [DW-1:0] remainder
);

  localparam int SW = $clog2(W + 1);

  logic          busy_r;
  logic          done_r;
  logic [SW-1:0] step_r;
  logic [W-1:0]  quot_r;
  logic [DW-1:0] rem_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_r, quot_r[W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= SW'(W);
      end else if (busy_r) begin
        step_r <= step_r - SW'(1);
        if (step_r == SW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quot_r <= {quot_r[W-2:0], ge};
    end
  end

  assign ctl.start = start;
  assign ctl.done  = done_r;
  assign quotient  = quot_r;
  assign remainder = rem_r;

endmodule

// ----- test/typed_allocation_range_table_top_test.sv -----
// ----------------------------------------------------------------------------
// typed_allocation_range_table_top_test
// drives alloc, free, lookup and no-op transactions through the allocation table,
// first from a directed table and then at random over a small pool of bases,
// and checks every result against a behavioural copy of the table
// ----------------------------------------------------------------------------
module typed_allocation_range_table_top_test;
  import tarit_pkg::*;

  localparam int ENTRIES = 64;
  localparam int ABITS   = 48;
  localparam int RANDOM_ITEMS = 1650;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    op_t                op;
    logic [ABITS-1:0]   address;
    logic [TYPE_W-1:0]  type_code;
    logic [COUNT_W-1:0] total;
    logic [SIZE_W-1:0]  bytes;
    bit                 typed_in;
    status_t            status;
    logic [TYPE_W-1:0]  found_type;
    logic [COUNT_W-1:0] remaining;
  } stim_row_t;

  typedef struct {
    status_t            status;
    logic [TYPE_W-1:0]  found_type;
    logic [COUNT_W-1:0] remaining;
  } answer_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_op;
  logic [ABITS-1:0] in_address;
  logic [TYPE_W-1:0] in_type_code;
  logic [COUNT_W-1:0] in_element_total;
  logic [SIZE_W-1:0] in_element_bytes;
  logic out_valid;
  logic out_stall;
  logic [1:0] out_status;
  logic [TYPE_W-1:0] out_found_type;
  logic [COUNT_W-1:0] out_remaining_elements;

  bit                 tbl_valid [ENTRIES];
  logic [ABITS-1:0]   tbl_base  [ENTRIES];
  logic [TYPE_W-1:0]  tbl_type  [ENTRIES];
  logic [COUNT_W-1:0] tbl_count [ENTRIES];
  logic [SIZE_W-1:0]  tbl_size  [ENTRIES];

  answer_t pending_answers[$];
  int errors;
  longint cycles;
  int send_idle_pct;
  int recv_idle_pct;
  logic [ABITS-1:0] base_pool[16];

  typed_allocation_range_table_top #(
    .TABLE_ENTRIES(ENTRIES),
    .ADDRESS_BITS(ABITS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_address(in_address),
    .in_type_code(in_type_code),
    .in_element_total(in_element_total),
    .in_element_bytes(in_element_bytes),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_found_type(out_found_type),
    .out_remaining_elements(out_remaining_elements)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int exact_slot(logic [ABITS-1:0] addr);
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_base[i] == addr) return i;
    end
    return -1;
  endfunction

  function automatic answer_t apply_to_table(op_t op, logic [ABITS-1:0] addr,
                                             logic [TYPE_W-1:0] ty,
                                             logic [COUNT_W-1:0] cnt,
                                             logic [SIZE_W-1:0] sz);
    answer_t a;
    int slot;
    logic [ABITS-1:0] best;
    logic [63:0] offset;
    logic [63:0] extent;
    a = '{ST_UNKNOWN, '0, '0};
    slot = exact_slot(addr);
    best = '0;
    case (op)
      OP_ALLOC: begin
        if (slot < 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (!tbl_valid[i]) begin
              slot = i;
              break;
            end
          end
        end
        if (slot < 0) begin
          a.status = ST_FULL;
        end else begin
          tbl_valid[slot] = 1'b1;
          tbl_base[slot] = addr;
          tbl_type[slot] = ty;
          tbl_count[slot] = cnt;
          tbl_size[slot] = sz;
          a.status = ST_OK;
        end
      end
      OP_FREE: begin
        if (slot >= 0) begin
          tbl_valid[slot] = 1'b0;
          a.status = ST_OK;
        end
      end
      OP_LOOKUP: begin
        if (slot >= 0) begin
          a = '{ST_OK, tbl_type[slot], tbl_count[slot]};
        end else begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_base[i] < addr && tbl_base[i] > best) begin
              best = tbl_base[i];
              slot = i;
            end
          end
          if (slot >= 0) begin
            offset = 64'(addr - best);
            extent = 64'(tbl_count[slot]) * 64'(tbl_size[slot]);
            if (offset >= extent) a.status = ST_UNKNOWN;
            else if (offset % 64'(tbl_size[slot]) != 0) a.status = ST_BADALIGN;
            else a = '{ST_OK, tbl_type[slot],
                       COUNT_W'(64'(tbl_count[slot]) - offset / 64'(tbl_size[slot]))};
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  task automatic send_transaction(op_t op, logic [ABITS-1:0] addr,
                                  logic [TYPE_W-1:0] ty, logic [COUNT_W-1:0] cnt,
                                  logic [SIZE_W-1:0] sz);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_op <= op;
    in_address <= addr;
    in_type_code <= ty;
    in_element_total <= cnt;
    in_element_bytes <= sz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_answers.push_back(apply_to_table(op, addr, ty, cnt, sz));
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    answer_t want;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected transaction", out_status, 0);
      end else begin
        want = pending_answers.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_found_type !== want.found_type)
          report_mismatch("found_type", out_found_type, want.found_type);
        if (out_remaining_elements !== want.remaining)
          report_mismatch("remaining_elements", out_remaining_elements, want.remaining);
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("typed_allocation_range_table_top test failed");
    $finish;
  end

  function automatic logic [ABITS-1:0] pick_address();
    logic [ABITS-1:0] b;
    b = base_pool[$urandom_range(15)];
    case ($urandom_range(5))
      0: return ABITS'({$urandom, $urandom});
      1: return b;
      default: return b + ABITS'($urandom_range(300));
    endcase
  endfunction

  initial begin
    stim_row_t rows[$];
    answer_t got;
    logic [ABITS-1:0] a;
    int op_pick;
    errors = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_NONE;
    in_address = '0;
    in_type_code = '0;
    in_element_total = '0;
    in_element_bytes = '0;
    out_stall = 1'b0;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    base_pool[0] = '0;
    base_pool[1] = '1 - 48'd400;
    for (int i = 2; i < 16; i++)
      base_pool[i] = ABITS'({$urandom, $urandom}) & 48'hFFFF_FFFF_FF00;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: expected result typed in where obvious
    rows = '{
      '{OP_LOOKUP, 48'h1000, 16'h0, 32'h0, 16'h0, 1, ST_UNKNOWN, 16'h0, 32'h0},
      '{OP_FREE, 48'h1000, 16'h0, 32'h0, 16'h0, 1, ST_UNKNOWN, 16'h0, 32'h0},
      '{OP_NONE, '1, '1, '1, '1, 1, ST_UNKNOWN, 16'h0, 32'h0},
      '{OP_ALLOC, 48'h0, 16'hFFFF, 32'd10, 16'd4, 1, ST_OK, 16'h0, 32'h0},
      '{OP_LOOKUP, 48'h0, 16'h0, 32'h0, 16'h0, 1, ST_OK, 16'hFFFF, 32'd10},
      '{OP_LOOKUP, 48'h4, 16'h0, 32'h0, 16'h0, 1, ST_UNKNOWN, 16'h0, 32'h0},
      '{OP_ALLOC, 48'h1000, 16'h1234, 32'd8, 16'd4, 1, ST_OK, 16'h0, 32'h0},
      '{OP_LOOKUP, 48'h1008, 16'h0, 32'h0, 16'h0, 1, ST_OK, 16'h1234, 32'd6},
      '{OP_LOOKUP, 48'h1009, 16'h0, 32'h0, 16'h0, 1, ST_BADALIGN, 16'h0, 32'h0},
      '{OP_LOOKUP, 48'h1020, 16'h0, 32'h0, 16'h0, 1, ST_UNKNOWN, 16'h0, 32'h0},
      '{OP_LOOKUP, 48'h101C, 16'h0, 32'h0, 16'h0, 1, ST_OK, 16'h1234, 32'd1},
      '{OP_ALLOC, 48'h1000, 16'h0055, 32'd0, 16'd0, 1, ST_OK, 16'h0, 32'h0},
      '{OP_LOOKUP, 48'h1000, 16'h0, 32'h0, 16'h0, 1, ST_OK, 16'h0055, 32'd0},
      '{OP_LOOKUP, 48'h1001, 16'h0, 32'h0, 16'h0, 1, ST_UNKNOWN, 16'h0, 32'h0},
      '{OP_ALLOC, 48'h2000, 16'h0, 32'hFFFF_FFFF, 16'hFFFF, 0, ST_OK, 16'h0, 32'h0},
      '{OP_LOOKUP, 48'h2000 + 48'hFFFF * 48'd3, 16'h0, 32'h0, 16'h0, 0,
        ST_OK, 16'h0, 32'h0},
      '{OP_ALLOC, '1 - 48'd7, 16'hA5A5, 32'h1, 16'h8, 0, ST_OK, 16'h0, 32'h0},
      '{OP_LOOKUP, '1, 16'h0, 32'h0, 16'h0, 0, ST_OK, 16'h0, 32'h0},
      '{OP_FREE, 48'h1000, 16'h0, 32'h0, 16'h0, 1, ST_OK, 16'h0, 32'h0},
      '{OP_LOOKUP, 48'h1004, 16'h0, 32'h0, 16'h0, 1, ST_UNKNOWN, 16'h0, 32'h0}
    };
    foreach (rows[r]) begin
      send_transaction(rows[r].op, rows[r].address, rows[r].type_code,
                       rows[r].total, rows[r].bytes);
      if (rows[r].typed_in) begin
        got = pending_answers[$];
        if (got.status !== rows[r].status || got.found_type !== rows[r].found_type ||
            got.remaining !== rows[r].remaining)
          report_mismatch("directed row", r, 0);
        pending_answers[$] = '{rows[r].status, rows[r].found_type, rows[r].remaining};
      end
    end
    // fill the table to force the full case
    for (int i = 0; i < ENTRIES + 2; i++)
      send_transaction(OP_ALLOC, 48'h10_0000 + 48'(i) * 48'h100, 16'(i), 32'd4, 16'd2);
    wait_drained();
    for (int i = 0; i < ENTRIES + 2; i++)
      send_transaction(OP_FREE, 48'h10_0000 + 48'(i) * 48'h100, '0, '0, '0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 57 : 0;
      recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 25 : 0;
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
        op_pick = $urandom_range(99);
        a = pick_address();
        if (n == 100) wait_drained();
        if (op_pick < 35)
          send_transaction(OP_ALLOC, base_pool[$urandom_range(15)],
                           16'($urandom), ($urandom_range(3) == 0) ? $urandom :
                           32'($urandom_range(64)),
                           ($urandom_range(7) == 0) ? 16'($urandom) :
                           16'($urandom_range(8)));
        else if (op_pick < 50)
          send_transaction(OP_FREE, ($urandom_range(3) == 0) ? a :
                           base_pool[$urandom_range(15)], '0, '0, '0);
        else if (op_pick < 97)
          send_transaction(OP_LOOKUP, a, '0, '0, '0);
        else
          send_transaction(OP_NONE, a, 16'($urandom), $urandom, 16'($urandom));
      end
    end
    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("typed_allocation_range_table_top test passed");
    else $display("typed_allocation_range_table_top test failed");
    $finish;
  end

endmodule
